FILE: sv/mnt_pkg.sv
// Package: shared types and constants of the mesh neighbor table.
package mnt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] ModeTick = 2'd0;
  localparam logic [1:0] ModeBeat = 2'd1;
  localparam logic [1:0] ModeLook = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StAdded    = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StOwn      = 3'd3;
  localparam logic [2:0] StDisabled = 3'd4;
  localparam logic [2:0] StNotFound = 3'd5;
  localparam logic [2:0] StEmpty    = 3'd6;

  // Register indexes.
  localparam logic [1:0] RegEnable   = 2'd0;
  localparam logic [1:0] RegOwnId    = 2'd1;
  localparam logic [1:0] RegInterval = 2'd2;
  localparam logic [1:0] RegTimeout  = 2'd3;

  // Kind of work the back end performs for a queued request.
  typedef enum logic [1:0] {
    OpNone  = 2'd0,
    OpSweep = 2'd1,
    OpBeat  = 2'd2,
    OpLook  = 2'd3
  } op_t;

  // Request classified by the front end.
  typedef struct packed {
    op_t         op;
    logic [2:0]  status;
    logic        due;
    logic [31:0] node_id;
    logic [7:0]  new_hop;
    logic [31:0] now_ms;
  } req_t;

  // Register file contents.
  typedef struct packed {
    logic        enable;
    logic [31:0] own_node_id;
    logic [15:0] heartbeat_interval_ms;
    logic [31:0] node_timeout_ms;
  } cfg_t;

endpackage

FILE: sv/mnt_front.sv
// Front end: register file, request classification and the heartbeat timer.
module mnt_front import mnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] node_id,
  input  logic [7:0]  rx_hop,
  input  logic [15:0] payload_len,
  input  logic [31:0] now_ms,
  output cfg_t        cfg,
  output req_t        req
);

  logic [31:0] last_hb;
  logic        wr;
  logic        due;
  logic [1:0]  ridx;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign ridx = paddr[3:2];

  // Write registers; hold last heartbeat time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.own_node_id <= 32'd1;
      cfg.heartbeat_interval_ms <= 16'd5000;
      cfg.node_timeout_ms <= 32'd10000;
      last_hb <= '0;
    end else begin
      if (wr) begin
        case (ridx)
          RegEnable: cfg.enable <= pwdata[0];
          RegOwnId: cfg.own_node_id <= pwdata;
          RegInterval: cfg.heartbeat_interval_ms <= pwdata[15:0];
          RegTimeout: cfg.node_timeout_ms <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall && cfg.enable && mode == ModeTick && due) begin
        last_hb <= now_ms;
      end
    end
  end

  // Return register contents.
  always_comb begin
    case (ridx)
      RegEnable: prdata = {31'd0, cfg.enable};
      RegOwnId: prdata = cfg.own_node_id;
      RegInterval: prdata = {16'd0, cfg.heartbeat_interval_ms};
      RegTimeout: prdata = cfg.node_timeout_ms;
      default: prdata = '0;
    endcase
  end

  assign due = (now_ms - last_hb) >= {16'd0, cfg.heartbeat_interval_ms};

  // Classify the request.
  always_comb begin
    req.status = StOk;
    req.op = OpNone;
    req.due = 1'b0;
    req.node_id = node_id;
    req.new_hop = rx_hop + 8'd1;
    req.now_ms = now_ms;
    if (!cfg.enable) begin
      req.status = StDisabled;
    end else begin
      case (mode)
        ModeTick: begin
          req.op = OpSweep;
          req.due = due;
        end
        ModeBeat: begin
          if (payload_len == 16'd0) req.status = StEmpty;
          else if (node_id == cfg.own_node_id) req.status = StOwn;
          else req.op = OpBeat;
        end
        ModeLook: begin
          if (payload_len == 16'd0) req.status = StEmpty;
          else req.op = OpLook;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/mnt_queue.sv
// Two-entry queue between front and back ends.
module mnt_queue import mnt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  req_t wr_data,
  output logic full,
  output logic rd_valid,
  input  logic rd_en,
  output req_t rd_data
);

  req_t slots [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data = slots[rp];

  // Advance pointers and store requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      cnt <= cnt + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wp] <= wr_data;
  end

endmodule

FILE: sv/mnt_back.sv
// Back end: walks the table one slot a cycle and produces results.
module mnt_back import mnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  req_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        found,
  output logic [3:0]  entry_index,
  output logic [7:0]  entry_hops,
  output logic        heartbeat_due,
  output logic [4:0]  removed_count,
  output logic [4:0]  active_count
);

  typedef enum logic [1:0] {SIdle, SWalk, SDone} state_t;

  state_t          state;
  logic [31:0]     ent_id   [TableDepth];
  logic [31:0]     ent_seen [TableDepth];
  logic [7:0]      ent_hop  [TableDepth];
  logic [TableDepth-1:0] ent_vld;
  logic [CntW-1:0] vcount;
  logic [IdxW-1:0] pos;
  logic [CntW-1:0] removed;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic            free;
  logic [IdxW-1:0] free_idx;
  req_t            cur;
  logic            last;
  logic            match;
  logic            aged;

  assign last = pos == IdxW'(TableDepth - 1);
  assign match = ent_vld[pos] && ent_id[pos] == cur.node_id;
  assign aged = ent_vld[pos] && (cur.now_ms - ent_seen[pos]) > cfg.node_timeout_ms;
  assign q_pop = state == SIdle && q_valid && (!out_valid || !out_stall);
  assign active_count = 5'(vcount);

  // Sequence one request: scan, then commit and present the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
      ent_vld <= '0;
      vcount <= '0;
      for (int i = 0; i < TableDepth; i++) begin
        ent_id[i] <= '0;
        ent_seen[i] <= '0;
        ent_hop[i] <= '0;
      end
    end else begin
      if (state == SDone) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        SIdle: begin
          if (q_pop) begin
            cur <= q_data;
            pos <= '0;
            removed <= '0;
            hit <= 1'b0;
            free <= 1'b0;
            hit_idx <= '0;
            free_idx <= '0;
            state <= (q_data.op == OpNone) ? SDone : SWalk;
          end
        end
        SWalk: begin
          if (cur.op == OpSweep) begin
            if (aged) begin
              ent_vld[pos] <= 1'b0;
              ent_id[pos] <= '0;
              removed <= removed + CntW'(1);
              if (vcount != '0) vcount <= vcount - CntW'(1);
            end
          end else begin
            if (match && !hit) begin
              hit <= 1'b1;
              hit_idx <= pos;
            end
            if (!ent_vld[pos] && !free) begin
              free <= 1'b1;
              free_idx <= pos;
            end
          end
          if (last) state <= SDone;
          else pos <= pos + IdxW'(1);
        end
        SDone: begin
          heartbeat_due <= cur.due;
          removed_count <= 5'(removed);
          case (cur.op)
            OpBeat: begin
              if (hit) begin
                ent_seen[hit_idx] <= cur.now_ms;
                status <= cur.status;
                found <= 1'b1;
                entry_index <= 4'(hit_idx);
                if (cur.new_hop < ent_hop[hit_idx]) begin
                  ent_hop[hit_idx] <= cur.new_hop;
                  entry_hops <= cur.new_hop;
                end else begin
                  entry_hops <= ent_hop[hit_idx];
                end
              end else if (free && vcount < CntW'(TableDepth)) begin
                ent_id[free_idx] <= cur.node_id;
                ent_seen[free_idx] <= cur.now_ms;
                ent_hop[free_idx] <= cur.new_hop;
                ent_vld[free_idx] <= 1'b1;
                vcount <= vcount + CntW'(1);
                status <= StAdded;
                found <= 1'b0;
                entry_index <= 4'(free_idx);
                entry_hops <= cur.new_hop;
              end else begin
                status <= StFull;
                found <= 1'b0;
                entry_index <= '0;
                entry_hops <= '0;
              end
            end
            OpLook: begin
              if (hit) begin
                status <= cur.status;
                found <= 1'b1;
                entry_index <= 4'(hit_idx);
                entry_hops <= ent_hop[hit_idx];
              end else begin
                status <= StNotFound;
                found <= 1'b0;
                entry_index <= '0;
                entry_hops <= '0;
              end
            end
            default: begin
              status <= cur.status;
              found <= 1'b0;
              entry_index <= '0;
              entry_hops <= '0;
            end
          endcase
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

endmodule

FILE: sv/mesh_neighbor_table_unit.sv
// Mesh neighbor table: front end, request queue and table-walking back end.
// An item that needs no table walk goes from the queue straight to the done state;
// others walk every slot first. The back end takes a new item only once it is idle.
// The front end takes items into a two-entry queue while the back end is busy.
// Reset (synchronous, rst high) clears the table, active count and queue and loads
// register defaults; no clearing pass is needed.
module mesh_neighbor_table_unit import mnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] node_id,
  input  logic [7:0]  rx_hop,
  input  logic [15:0] payload_len,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        found,
  output logic [3:0]  entry_index,
  output logic [7:0]  entry_hops,
  output logic        heartbeat_due,
  output logic [4:0]  removed_count,
  output logic [4:0]  active_count
);

  cfg_t cfg;
  req_t req, q_data;
  logic q_full, q_valid, q_pop;

  assign in_stall = q_full;

  mnt_front u_front (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .mode, .node_id, .rx_hop, .payload_len, .now_ms,
    .cfg, .req
  );

  mnt_queue u_queue (
    .clk, .rst, .wr_en(in_valid && !q_full), .wr_data(req), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_pop), .rd_data(q_data)
  );

  mnt_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_data, .q_pop, .out_valid, .out_stall,
    .status, .found, .entry_index, .entry_hops, .heartbeat_due,
    .removed_count, .active_count
  );

endmodule

FILE: sv/mnt_checker.sv
// Port-level checker for the mesh neighbor table, bound to the top level.
module mnt_checker import mnt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic       found,
  input logic [4:0] active_count,
  input logic [4:0] removed_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");

  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == StOk)
    else $error("found with nonzero status");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> active_count <= 5'd16 && removed_count <= 5'd16)
    else $error("count out of range");

  a_sweep: assert property (@(posedge clk) disable iff (rst)
    out_valid && removed_count != 5'd0 |-> status == StOk && !found)
    else $error("removal on non-tick");

endmodule

bind mesh_neighbor_table_unit mnt_checker u_checker (
  .clk, .rst, .out_valid, .out_stall, .status, .found, .active_count, .removed_count
);
